FILE: design/cle_pkg.sv
// ----------------------------------------------------------------------------
// Line edit buffer package
// Shared widths, command codes and status codes for the gap-buffer line
// editor.
// ----------------------------------------------------------------------------
package cle_pkg;

   // Default text capacity in characters.
   localparam int CAPACITY_DEF = 4096;

   // Fixed field widths of the command and response items.
   localparam int CMD_W   = 3;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 12;
   localparam int COUNT_W = 13;
   localparam int STAT_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      OP_LEFT   = 3'd0,
      OP_RIGHT  = 3'd1,
      OP_BACK   = 3'd2,
      OP_INSERT = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EDGE  = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

FILE: design/cursor_line_edit_buffer.sv
// ----------------------------------------------------------------------------
// Cursor line edit buffer
// One-line text editor with a cursor, kept as a gap buffer in a single
// synchronous memory: cursor moves, backspace, insert and indexed reads.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  ----------------------------------------------
//  command   start / busy       req_cmd, req_char_in, req_read_index
//  response  rsp_valid strobe   rsp_char_out, rsp_text_length, rsp_cursor_pos,
//                               rsp_status
//
//  For each item, the cycle it is accepted issues any memory read the
//  command needs, and the next cycle does any memory write and updates
//  the gap pointers; busy is high during that write-back cycle. The
//  response strobe is high for one cycle right after it. After reset the
//  text is empty and the cursor at position 0. The receiver cannot stall;
//  each item gives exactly one response.
//
module cursor_line_edit_buffer #(
   parameter int CAPACITY = cle_pkg::CAPACITY_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [cle_pkg::CMD_W-1:0]   req_cmd,
   input  logic [cle_pkg::CHAR_W-1:0]  req_char_in,
   input  logic [cle_pkg::INDEX_W-1:0] req_read_index,
   output logic                        rsp_valid,
   output logic [cle_pkg::CHAR_W-1:0]  rsp_char_out,
   output logic [cle_pkg::COUNT_W-1:0] rsp_text_length,
   output logic [cle_pkg::COUNT_W-1:0] rsp_cursor_pos,
   output logic [cle_pkg::STAT_W-1:0]  rsp_status
);
   import cle_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int GW = $clog2(CAPACITY + 1);
   localparam int XW = ((GW > INDEX_W) ? GW : INDEX_W) + 1;
   localparam int LW = (GW > COUNT_W) ? GW : COUNT_W;
   localparam logic [GW-1:0] CAP_G = GW'(CAPACITY);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type               state_ff, state_in;
   logic [GW-1:0]           gap_start_ff, gap_start_in;
   logic [GW-1:0]           gap_end_ff, gap_end_in;
   logic [CMD_W-1:0]        op_ff, op_in;
   logic [CHAR_W-1:0]       char_ff, char_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic [COUNT_W-1:0]      rsp_length_ff, rsp_length_in;
   logic [COUNT_W-1:0]      rsp_cursor_ff, rsp_cursor_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;

   logic [CHAR_W-1:0]       text_store [CAPACITY];
   logic [CHAR_W-1:0]       rd_data_ff;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [CHAR_W-1:0]       wr_data;

   always_comb begin
      logic          accept;
      logic [GW-1:0] gap_len;
      logic [XW-1:0] idx_x;
      logic [XW-1:0] len_x;
      logic [XW-1:0] pos_x;
      logic [GW-1:0] start_dec;
      logic [LW-1:0] len_after;

      accept    = start && (state_ff == S_IDLE);
      gap_len   = gap_end_ff - gap_start_ff;
      idx_x     = XW'(req_read_index);
      len_x     = XW'(CAP_G - gap_len);
      pos_x     = (idx_x < XW'(gap_start_ff)) ? idx_x : idx_x + XW'(gap_len);
      start_dec = gap_start_ff - GW'(1);
      len_after = '0;

      state_in      = state_ff;
      gap_start_in  = gap_start_ff;
      gap_end_in    = gap_end_ff;
      op_in         = op_ff;
      char_in       = char_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_length_in = rsp_length_ff;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = start_dec[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = gap_start_ff[AW-1:0];
      wr_data       = char_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_EXEC;
               op_in     = req_cmd;
               char_in   = req_char_in;
               status_in = ST_DONE;
               // Decide the outcome now and fetch the entry the command needs.
               case (req_cmd)
                  OP_LEFT: begin
                     if (gap_start_ff == '0) begin
                        status_in = ST_EDGE;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = start_dec[AW-1:0];
                     end
                  end
                  OP_RIGHT: begin
                     if (gap_end_ff >= CAP_G) begin
                        status_in = ST_EDGE;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = gap_end_ff[AW-1:0];
                     end
                  end
                  OP_BACK: begin
                     if (gap_start_ff == '0) begin
                        status_in = ST_EDGE;
                     end
                  end
                  OP_INSERT: begin
                     if (gap_start_ff >= gap_end_ff) begin
                        status_in = ST_FULL;
                     end
                  end
                  OP_READ: begin
                     if (idx_x >= len_x) begin
                        status_in = ST_RANGE;
                     end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_x[AW-1:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EXEC: begin
            state_in    = S_IDLE;
            rsp_char_in = '0;
            if (status_ff == ST_DONE) begin
               case (op_ff)
                  OP_LEFT: begin
                     gap_start_in = start_dec;
                     gap_end_in   = gap_end_ff - GW'(1);
                     wr_en        = 1'b1;
                     wr_addr      = gap_end_in[AW-1:0];
                     wr_data      = rd_data_ff;
                  end
                  OP_RIGHT: begin
                     gap_start_in = gap_start_ff + GW'(1);
                     gap_end_in   = gap_end_ff + GW'(1);
                     wr_en        = 1'b1;
                     wr_addr      = gap_start_ff[AW-1:0];
                     wr_data      = rd_data_ff;
                  end
                  OP_BACK: begin
                     gap_start_in = start_dec;
                  end
                  OP_INSERT: begin
                     gap_start_in = gap_start_ff + GW'(1);
                     wr_en        = 1'b1;
                     wr_addr      = gap_start_ff[AW-1:0];
                     wr_data      = char_ff;
                  end
                  OP_READ: begin
                     rsp_char_in = rd_data_ff;
                  end
                  default: begin
                  end
               endcase
            end
            len_after     = LW'(CAP_G - (gap_end_in - gap_start_in));
            rsp_valid_in  = 1'b1;
            rsp_length_in = len_after[COUNT_W-1:0];
            rsp_cursor_in = COUNT_W'(gap_start_in);
            rsp_status_in = status_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gap_start_ff <= '0;
         gap_end_ff   <= CAP_G;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_start_ff <= gap_start_in;
         gap_end_ff   <= gap_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      char_ff       <= char_in;
      status_ff     <= status_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_length_ff <= rsp_length_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Text memory: one read port and one write port, read data registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= text_store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_store[wr_addr] <= wr_data;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_text_length = rsp_length_ff;
   assign rsp_cursor_pos  = rsp_cursor_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

FILE: bench/cursor_line_edit_buffer_test.sv
// ----------------------------------------------------------------------------
// Cursor line edit buffer testbench
// Drives cursor moves, backspaces, inserts, reads and unused command codes
// into the gap-buffer editor. A shadow gap buffer works out the reply to
// every accepted item, and each response strobe is checked field by field.
// The run covers an empty buffer, a short hand-written edit sequence and a
// random edit mix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_line_edit_buffer_test;
   import cle_pkg::*;

   localparam int TEXT_CAP    = CAPACITY_DEF;
   localparam int STALL_LIMIT = 500;
   localparam int PRINT_LIMIT = 100;

   typedef struct {
      logic [CHAR_W-1:0]  char_out;
      logic [COUNT_W-1:0] text_length;
      logic [COUNT_W-1:0] cursor_pos;
      status_type         status;
   } edit_reply_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd        = '0;
   logic [CHAR_W-1:0]   req_char_in    = '0;
   logic [INDEX_W-1:0]  req_read_index = '0;
   logic                rsp_valid;
   logic [CHAR_W-1:0]   rsp_char_out;
   logic [COUNT_W-1:0]  rsp_text_length;
   logic [COUNT_W-1:0]  rsp_cursor_pos;
   logic [STAT_W-1:0]   rsp_status;

   // Shadow copy of the gap buffer: text is [0, gap_lo) then [gap_hi, TEXT_CAP).
   logic [CHAR_W-1:0]   shadow_text [TEXT_CAP];
   int unsigned         shadow_gap_lo = 0;
   int unsigned         shadow_gap_hi = TEXT_CAP;

   edit_reply_type      edit_replies [$];
   int                  mismatch_count = 0;
   int                  stalled_cycles = 0;
   bit                  burst_mode     = 1'b0;

   cursor_line_edit_buffer #(
      .CAPACITY        (TEXT_CAP)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_char_in     (req_char_in),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_char_out    (rsp_char_out),
      .rsp_text_length (rsp_text_length),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned text_length_now();
      return TEXT_CAP - (shadow_gap_hi - shadow_gap_lo);
   endfunction

   // Applies one command to the shadow buffer and returns the reply it gives.
   function automatic edit_reply_type apply_edit(input logic [CMD_W-1:0] cmd,
                                                 input logic [CHAR_W-1:0] ch,
                                                 input logic [INDEX_W-1:0] idx);
      edit_reply_type reply;
      int unsigned gap_size;
      int unsigned spot;
      reply.char_out = '0;
      reply.status   = ST_DONE;
      case (cmd)
         OP_LEFT: begin
            if (shadow_gap_lo == 0) begin
               reply.status = ST_EDGE;
            end else begin
               shadow_gap_lo--;
               shadow_gap_hi--;
               shadow_text[shadow_gap_hi] = shadow_text[shadow_gap_lo];
            end
         end
         OP_RIGHT: begin
            if (shadow_gap_hi >= TEXT_CAP) begin
               reply.status = ST_EDGE;
            end else begin
               shadow_text[shadow_gap_lo] = shadow_text[shadow_gap_hi];
               shadow_gap_lo++;
               shadow_gap_hi++;
            end
         end
         OP_BACK: begin
            if (shadow_gap_lo == 0) reply.status = ST_EDGE;
            else shadow_gap_lo--;
         end
         OP_INSERT: begin
            if (shadow_gap_lo >= shadow_gap_hi) begin
               reply.status = ST_FULL;
            end else begin
               shadow_text[shadow_gap_lo] = ch;
               shadow_gap_lo++;
            end
         end
         OP_READ: begin
            gap_size = shadow_gap_hi - shadow_gap_lo;
            if (idx >= TEXT_CAP - gap_size) begin
               reply.status = ST_RANGE;
            end else begin
               // Indexes at or right of the cursor skip over the gap.
               spot = (idx < shadow_gap_lo) ? idx : idx + gap_size;
               reply.char_out = shadow_text[spot];
            end
         end
         default: ;
      endcase
      reply.text_length = COUNT_W'(text_length_now());
      reply.cursor_pos  = COUNT_W'(shadow_gap_lo);
      return reply;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Sends one item and leaves start high when the next item follows at once.
   task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                input logic [CHAR_W-1:0] ch,
                                input logic [INDEX_W-1:0] idx);
      int unsigned pick;
      int unsigned gap;
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_char_in    <= ch;
      req_read_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      edit_replies.push_back(apply_edit(cmd, ch, idx));
      pick = $urandom_range(0, 99);
      if (burst_mode || pick < 40) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      while (edit_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_buffer();
      issue_command(OP_LEFT, 8'hFF, '1);
      issue_command(OP_RIGHT, 8'h00, '0);
      issue_command(OP_BACK, 8'hA5, 12'h5A5);
      issue_command(OP_READ, 8'h00, 12'd0);
      issue_command(OP_READ, 8'hFF, 12'd4095);
      // Unused command codes must leave everything alone.
      for (int c = int'(OP_READ) + 1; c < (1 << CMD_W); c++) begin
         issue_command(CMD_W'(c), CHAR_W'($urandom), INDEX_W'($urandom));
      end
   endtask

   task automatic test_directed_edits();
      issue_command(OP_INSERT, "L", 12'hFFF);
      issue_command(OP_INSERT, 8'h00, 12'h000);
      issue_command(OP_INSERT, 8'hFF, 12'hAAA);
      issue_command(OP_INSERT, "D", 12'h555);
      issue_command(OP_RIGHT, "B", 12'd0);
      issue_command(OP_READ, 8'h00, 12'd0);
      issue_command(OP_READ, 8'hFF, 12'd3);
      issue_command(OP_READ, 8'h00, 12'd4);
      issue_command(OP_LEFT, "P", 12'd0);
      issue_command(OP_LEFT, 8'h00, 12'd0);
      // Insert and delete in the middle of the text, then read past the gap.
      issue_command(OP_INSERT, "B", 12'd0);
      issue_command(OP_BACK, 8'h00, 12'd0);
      issue_command(OP_READ, 8'h00, 12'd2);
      issue_command(OP_LEFT, 8'h00, 12'd0);
      issue_command(OP_LEFT, 8'h00, 12'd0);
      issue_command(OP_LEFT, 8'h00, 12'd0);
      issue_command(OP_BACK, 8'h00, 12'd0);
      issue_command(OP_INSERT, "P", 12'd0);
      wait_for_replies();
   endtask

   task automatic test_random_edits();
      int unsigned pick;
      int unsigned span;
      logic [INDEX_W-1:0] idx;
      for (int n = 0; n < 500; n++) begin
         if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         if (n == 250) wait_for_replies();
         pick = $urandom_range(0, 99);
         span = text_length_now() + 1;
         idx  = ($urandom_range(0, 3) != 0) ? INDEX_W'($urandom_range(0, span))
                                            : INDEX_W'($urandom);
         if (pick < 30) issue_command(OP_INSERT, CHAR_W'($urandom), idx);
         else if (pick < 45) issue_command(OP_LEFT, CHAR_W'($urandom), idx);
         else if (pick < 60) issue_command(OP_RIGHT, CHAR_W'($urandom), idx);
         else if (pick < 75) issue_command(OP_BACK, CHAR_W'($urandom), idx);
         else if (pick < 95) issue_command(OP_READ, CHAR_W'($urandom), idx);
         else issue_command(CMD_W'($urandom_range(int'(OP_READ) + 1, (1 << CMD_W) - 1)),
                            CHAR_W'($urandom), idx);
      end
      burst_mode = 1'b0;
   endtask

   always @(posedge clock) begin : reply_check
      edit_reply_type want;
      if (!reset && rsp_valid) begin
         if (edit_replies.size() == 0) begin
            report_mismatch("response with no command waiting");
         end else begin
            want = edit_replies.pop_front();
            if (rsp_char_out !== want.char_out)
               report_mismatch($sformatf("char_out %0h, wanted %0h",
                                         rsp_char_out, want.char_out));
            if (rsp_text_length !== want.text_length)
               report_mismatch($sformatf("text_length %0d, wanted %0d",
                                         rsp_text_length, want.text_length));
            if (rsp_cursor_pos !== want.cursor_pos)
               report_mismatch($sformatf("cursor_pos %0d, wanted %0d",
                                         rsp_cursor_pos, want.cursor_pos));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, wanted %0d",
                                         rsp_status, want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) stalled_cycles = 0;
      else stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("cursor_line_edit_buffer_test: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_buffer();
      test_directed_edits();
      test_random_edits();
      wait_for_replies();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cursor_line_edit_buffer_test: PASS");
      end else begin
         $display("cursor_line_edit_buffer_test: FAIL");
      end
      $finish;
   end

endmodule
